// ----- src/jcc_pkg.sv -----
// Shared constants and the halfwidth kana table for the Japanese code converter.
// No dependencies; imported by jcc_convert and japanese_code_converter_core.
package jcc_pkg;

	localparam int CodeW = 16;
	localparam int ModeW = 3;

	// conversion_mode codes
	localparam logic [ModeW-1:0] MODE_SJIS_TO_JIS = 3'd0;
	localparam logic [ModeW-1:0] MODE_SJIS_TO_EUC = 3'd1;
	localparam logic [ModeW-1:0] MODE_JIS_TO_SJIS = 3'd2;
	localparam logic [ModeW-1:0] MODE_JIS_TO_EUC  = 3'd3;
	localparam logic [ModeW-1:0] MODE_EUC_TO_JIS  = 3'd4;

	localparam logic [7:0] KANA_PREFIX = 8'h8e;
	localparam logic [7:0] KANA_FIRST  = 8'ha0;
	localparam logic [7:0] KANA_LAST   = 8'hdf;

	typedef logic [CodeW-1:0] code_t;
	typedef logic [ModeW-1:0] mode_t;

	// Halfwidth kana (offset from 0xA0) to fullwidth JIS
	function automatic code_t kana_rom(input logic [5:0] idx);
		code_t r;
		case (idx)
			6'd0:  r = 16'h2121; 6'd1:  r = 16'h2123; 6'd2:  r = 16'h2156; 6'd3:  r = 16'h2157;
			6'd4:  r = 16'h2122; 6'd5:  r = 16'h2126; 6'd6:  r = 16'h2572; 6'd7:  r = 16'h2521;
			6'd8:  r = 16'h2523; 6'd9:  r = 16'h2525; 6'd10: r = 16'h2527; 6'd11: r = 16'h2529;
			6'd12: r = 16'h2563; 6'd13: r = 16'h2565; 6'd14: r = 16'h2567; 6'd15: r = 16'h2543;
			6'd16: r = 16'h213c; 6'd17: r = 16'h2522; 6'd18: r = 16'h2524; 6'd19: r = 16'h2526;
			6'd20: r = 16'h2528; 6'd21: r = 16'h252a; 6'd22: r = 16'h252b; 6'd23: r = 16'h252d;
			6'd24: r = 16'h252f; 6'd25: r = 16'h2531; 6'd26: r = 16'h2533; 6'd27: r = 16'h2535;
			6'd28: r = 16'h2537; 6'd29: r = 16'h2539; 6'd30: r = 16'h253b; 6'd31: r = 16'h253d;
			6'd32: r = 16'h253f; 6'd33: r = 16'h2541; 6'd34: r = 16'h2544; 6'd35: r = 16'h2546;
			6'd36: r = 16'h2548; 6'd37: r = 16'h254a; 6'd38: r = 16'h254b; 6'd39: r = 16'h254c;
			6'd40: r = 16'h254d; 6'd41: r = 16'h254e; 6'd42: r = 16'h254f; 6'd43: r = 16'h2552;
			6'd44: r = 16'h2555; 6'd45: r = 16'h2558; 6'd46: r = 16'h255b; 6'd47: r = 16'h255e;
			6'd48: r = 16'h255f; 6'd49: r = 16'h2560; 6'd50: r = 16'h2561; 6'd51: r = 16'h2562;
			6'd52: r = 16'h2564; 6'd53: r = 16'h2566; 6'd54: r = 16'h2568; 6'd55: r = 16'h2569;
			6'd56: r = 16'h256a; 6'd57: r = 16'h256b; 6'd58: r = 16'h256c; 6'd59: r = 16'h256d;
			6'd60: r = 16'h256f; 6'd61: r = 16'h2573; 6'd62: r = 16'h212b; 6'd63: r = 16'h212c;
			default: r = 16'h0000;
		endcase
		return r;
	endfunction

endpackage

// ----- src/jcc_convert.sv -----
// Combinational code conversion for one two-byte code, selected by mode.
// Depends on jcc_pkg.
module jcc_convert (
	input  jcc_pkg::mode_t mode,
	input  jcc_pkg::code_t code,
	output jcc_pkg::code_t result
);
	import jcc_pkg::*;

	logic [7:0]  hi_in, lo_in;
	logic [7:0]  row;
	// Shift_JIS to JIS
	logic [7:0]  sj_lo1;
	logic        sj_up;
	logic [15:0] sj_lo;
	code_t       sj_res;
	// Shift_JIS to EUC
	logic        se_up;
	logic [15:0] se_lo;
	logic [7:0]  se_hi;
	code_t       se_res;
	// JIS to Shift_JIS
	logic [15:0] js_lo0, js_lo;
	logic [8:0]  js_d;
	logic [8:0]  js_sum;
	logic        js_big;
	logic [7:0]  js_hi;
	code_t       js_res;
	// EUC to JIS
	logic [7:0]  kofs;
	code_t       ej_res;

	assign hi_in = code[15:8];
	assign lo_in = code[7:0];

	// lead byte to row, kept modulo 256
	assign row = {hi_in - ((hi_in <= 8'h9f) ? 8'h71 : 8'hb1)} << 1 | 8'h01;

	always_comb begin
		sj_lo1 = lo_in - {7'd0, (lo_in > 8'h7f)};
		sj_up  = (sj_lo1 >= 8'h9e);
		sj_lo  = {8'd0, sj_lo1} - (sj_up ? 16'h007d : 16'h001f);
		sj_res = {row + {7'd0, sj_up}, 8'd0} | sj_lo;
	end

	always_comb begin
		se_up = (lo_in >= 8'h9f);
		if (se_up) begin
			se_lo = {8'd0, lo_in} - 16'h007e;
		end else if (lo_in > 8'h7f) begin
			se_lo = {8'd0, lo_in} - 16'h0020;
		end else begin
			se_lo = {8'd0, lo_in} - 16'h001f;
		end
		se_hi  = (row + {7'd0, se_up}) | 8'h80;
		se_res = {se_hi, 8'd0} | se_lo | 16'h0080;
	end

	always_comb begin
		js_lo0 = {8'd0, lo_in} + (hi_in[0] ? 16'h001f : 16'h007d);
		js_lo  = js_lo0 + {15'd0, (js_lo0 >= 16'h007f)};
		// a borrow here means the wide value wrapped and is far above 0x9f
		js_d   = {1'b0, hi_in} - 9'h021;
		js_sum = {1'b0, js_d[8], js_d[7:1]} + 9'h081;
		js_big = js_d[8] || (js_sum > 9'h09f);
		js_hi  = js_sum[7:0] + (js_big ? 8'h40 : 8'h00);
		js_res = {js_hi, 8'd0} | js_lo;
	end

	always_comb begin
		kofs = lo_in - KANA_FIRST;
		if (hi_in == KANA_PREFIX) begin
			if (lo_in < KANA_FIRST || lo_in > KANA_LAST) begin
				ej_res = '0;
			end else begin
				ej_res = kana_rom(kofs[5:0]);
			end
		end else begin
			ej_res = code & ~16'h8080;
		end
	end

	always_comb begin
		case (mode)
			MODE_SJIS_TO_JIS: result = sj_res;
			MODE_SJIS_TO_EUC: result = se_res;
			MODE_JIS_TO_SJIS: result = js_res;
			MODE_JIS_TO_EUC:  result = code | 16'h8080;
			MODE_EUC_TO_JIS:  result = ej_res;
			default:          result = '0;
		endcase
	end

endmodule

// ----- src/japanese_code_converter_core.sv -----
// Top level of the Japanese double-byte code converter: stream ports, mode
// register, input and result registers. Depends on jcc_pkg and jcc_convert.
//
// Usage:
//  - Slave stream s_*: one 16-bit code per transfer, lead byte in tdata[15:8].
//  - Master stream m_*: one converted 16-bit code per input transfer, in order.
//  - cfg_wen/cfg_wdata write conversion_mode (0 SJIS->JIS, 1 SJIS->EUC,
//    2 JIS->SJIS, 3 JIS->EUC, 4 EUC->JIS; 5..7 give zero). Write it only when
//    the converter is empty; it is applied to the code held in the input
//    register as it moves to the result register.
//  - A code taken into the input register (_s1) is converted and registered
//    in the result register (_s2), which drives m_tdata. Throughput: one
//    transfer per cycle while m_tready is high (single-pass conversion logic).
//  - Stall: while m_tready is low the result holds; the input register still
//    takes one more code, so s_tready only drops when both stages are full.
//  - Reset (arst_n low, asynchronous): both stages empty, mode = SJIS->JIS.
module japanese_code_converter_core (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  jcc_pkg::code_t        s_tdata,   // [15:0] source_code
	// master stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output jcc_pkg::code_t        m_tdata,   // [15:0] converted_code
	// configuration
	input  logic                  cfg_wen,
	input  jcc_pkg::mode_t        cfg_wdata  // [2:0] conversion_mode
);
	import jcc_pkg::*;

	mode_t mode_q;
	logic  valid_s1, valid_s2;
	code_t code_s1, result_s2;
	code_t conv;
	logic  ready_s2;  // result register can take a new code this cycle
	logic  ready_s1;

	assign ready_s2 = !valid_s2 || m_tready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign s_tready = ready_s1;
	assign m_tvalid = valid_s2;
	assign m_tdata  = result_s2;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SJIS_TO_JIS;
		end else if (cfg_wen) begin
			mode_q <= cfg_wdata;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload: input register
	always_ff @(posedge clk) begin
		if (ready_s1 && s_tvalid) begin
			code_s1 <= s_tdata;
		end
	end

	jcc_convert u_convert (
		.mode   (mode_q),
		.code   (code_s1),
		.result (conv)
	);

	// payload: result register
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			result_s2 <= conv;
		end
	end

	// a new result only appears when the input register held a code
	a_rise_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result valid without a code in the input register");

	// a code waiting behind a stalled result register is kept
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !ready_s2) |=> (valid_s1 && $stable(code_s1)))
		else $error("input register lost a code under stall");

	// JIS to EUC always sets the high bit of both bytes
	a_euc_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && mode_q == MODE_JIS_TO_EUC) |-> (m_tdata[15] && m_tdata[7]))
		else $error("EUC result without high bits");

	// EUC to JIS gives 7-bit bytes (table entries and zero included)
	a_jis_bits: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && mode_q == MODE_EUC_TO_JIS) |-> (!m_tdata[15] && !m_tdata[7]))
		else $error("JIS result with high bits set");

	// unused modes give zero
	a_unused_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (mode_q > MODE_EUC_TO_JIS)) |-> (m_tdata == '0))
		else $error("unused mode gave a non-zero result");

endmodule
